// ----- rtl/pressure_sensor_compensation_defines.svh -----
// assertion macros for the pressure sensor compensation block
// used by the top level; no other dependencies
`ifndef PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_DEFINES_SVH
`ifndef SYNTHESIS
`define PSC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("psc assertion failed");
`define PSC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("psc assertion failed");
`else
`define PSC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PSC_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/psc_pkg.sv -----
// shared types and constants for the pressure sensor compensation block
// no dependencies
`default_nettype none
package psc_pkg;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        start;
    logic        mul_only;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [63:0] result;
  } md_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/psc_ifs.sv -----
// valid/ready channel interfaces for raw samples and compensated results
// no dependencies
`default_nettype none
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic [23:0]        pressure_centipascal;
  logic [23:0]        pressure_filtered;
  logic               filter_updated;
  logic               divide_fault;
  modport source (output valid, temperature_tenths, pressure_centipascal,
                  pressure_filtered, filter_updated, divide_fault, input ready);
  modport sink (input valid, temperature_tenths, pressure_centipascal,
                pressure_filtered, filter_updated, divide_fault, output ready);
endinterface
`default_nettype wire

// ----- rtl/psc_muldiv.sv -----
// bit-serial signed multiply then divide unit: trunc(a*b/c), saturated to 64 bits;
// multiply-only mode gives the low 64 bits of a*b, and c of zero gives zero; depends on psc_pkg
`default_nettype none
module psc_muldiv (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire psc_pkg::md_req_t req,
  output psc_pkg::md_rsp_t      rsp
);
  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_CHK  = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_FIN  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [63:0]  ua_r, ua_nxt;
  logic [63:0]  uc_r, uc_nxt;
  logic         neg_r, neg_nxt;
  logic         mode_r, mode_nxt;
  logic         zero_r, zero_nxt;
  logic         ovf_r, ovf_nxt;
  logic [64:0]  sum;
  logic [63:0]  shifted;
  logic         ge;
  logic [63:0]  q;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    ua_nxt    = ua_r;
    uc_nxt    = uc_r;
    neg_nxt   = neg_r;
    mode_nxt  = mode_r;
    zero_nxt  = zero_r;
    ovf_nxt   = ovf_r;
    sum       = prod_r[0] ? ({1'b0, prod_r[127:64]} + {1'b0, ua_r})
                          : {1'b0, prod_r[127:64]};
    shifted   = {prod_r[126:64], prod_r[63]};
    ge        = prod_r[127] || (shifted >= uc_r);
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          ua_nxt    = req.a[63] ? (64'd0 - req.a) : req.a;
          uc_nxt    = req.c[63] ? (64'd0 - req.c) : req.c;
          prod_nxt  = {64'd0, (req.b[63] ? (64'd0 - req.b) : req.b)};
          neg_nxt   = req.mul_only ? (req.a[63] ^ req.b[63])
                                   : (req.a[63] ^ req.b[63] ^ req.c[63]);
          mode_nxt  = req.mul_only;
          zero_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = 6'd63;
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        prod_nxt = {sum, prod_r[63:1]};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = mode_r ? U_FIN : U_CHK;
        end
      end
      U_CHK: begin
        cnt_nxt = 6'd63;
        if (uc_r == 64'd0) begin
          zero_nxt  = 1'b1;
          state_nxt = U_FIN;
        end else if (prod_r[127:64] >= uc_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = U_FIN;
        end else begin
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        prod_nxt = {(ge ? (shifted - uc_r) : shifted), prod_r[62:0], ge};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = U_FIN;
        end
      end
      U_FIN: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_comb begin
    if (mode_r) begin
      q = prod_r[63:0];
    end else if (zero_r) begin
      q = 64'd0;
    end else if (ovf_r || prod_r[63]) begin
      q = psc_pkg::INT64_MAX;
    end else begin
      q = prod_r[63:0];
    end
    rsp.result = neg_r ? (64'd0 - q) : q;
    rsp.done   = (state_r == U_FIN);
    rsp.busy   = (state_r != U_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    ua_r   <= ua_nxt;
    uc_r   <= uc_nxt;
    neg_r  <= neg_nxt;
    mode_r <= mode_nxt;
    zero_r <= zero_nxt;
    ovf_r  <= ovf_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/pressure_sensor_compensation.sv -----
// top level: barometric sensor compensation with calibration registers
// depends on psc_pkg, psc_ifs, psc_muldiv and the defines header
//
// in_chan takes one word holding a raw 20-bit pressure and temperature count;
// out_chan gives one word per input: temperature in tenths, pressure in
// centipascal, the filtered pressure and the update and divide fault flags.
// The twelve calibration values are written over the APB-style cfg_ port,
// 64-bit data, register i at byte address 8*i; the user must write them
// only while the block is idle, and the block itself does not enforce it.
// One shared bit-serial multiply/divide unit does all the general multiplies and
// divides, one bit per cycle, and takes one operation at a time. The next
// word is accepted only once the last result has moved to the output
// register, and in_chan.ready is high only between words.
// The result sits in an output register, so a stalled receiver holds it
// while the next word is already accepted and computed; the finished
// result then waits for the register to free up.
// Reset clears all calibration registers and the filtered pressure to zero.
`default_nettype none
`include "pressure_sensor_compensation_defines.svh"
module pressure_sensor_compensation #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  psc_in_if.sink           in_chan,
  psc_out_if.source        out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [1:0] REG_TEMP  = 2'd0;
  localparam logic [1:0] REG_P1_4  = 2'd1;
  localparam logic [1:0] REG_P5_8  = 2'd2;
  localparam logic [1:0] REG_P9    = 2'd3;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_HH   = 5'd4;
  localparam logic [4:0] S_W1   = 5'd5;
  localparam logic [4:0] S_W2   = 5'd6;
  localparam logic [4:0] S_V1   = 5'd7;
  localparam logic [4:0] S_V2   = 5'd8;
  localparam logic [4:0] S_EN   = 5'd9;
  localparam logic [4:0] S_D1   = 5'd10;
  localparam logic [4:0] S_D2   = 5'd11;
  localparam logic [4:0] S_D3   = 5'd12;
  localparam logic [4:0] S_D4   = 5'd13;
  localparam logic [4:0] S_D5   = 5'd14;
  localparam logic [4:0] S_D6   = 5'd15;
  localparam logic [4:0] S_D7   = 5'd16;
  localparam logic [4:0] S_D8   = 5'd17;
  localparam logic [4:0] S_D9   = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SCALE_Q  = 64'sd1 <<< (24 + FRAC_BITS);
  localparam logic signed [63:0] THRESH_Q = 64'sd5000000 <<< FRAC_BITS;
  localparam logic signed [63:0] DIV20_Q  = 64'sd20 <<< FRAC_BITS;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? psc_pkg::INT64_MIN : psc_pkg::INT64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [23:0] clamp24(input logic signed [63:0] v);
    if (v < 0) begin
      return 24'd0;
    end else if (v > 64'sd16777215) begin
      return 24'hFFFFFF;
    end
    return v[23:0];
  endfunction

  // configuration
  logic [47:0] cal_temp_r;
  logic [63:0] cal_p14_r;
  logic [63:0] cal_p58_r;
  logic [15:0] cal_p9_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[4:3])
      REG_TEMP: cfg_prdata = {16'd0, cal_temp_r};
      REG_P1_4: cfg_prdata = cal_p14_r;
      REG_P5_8: cfg_prdata = cal_p58_r;
      REG_P9:   cfg_prdata = {48'd0, cal_p9_r};
      default:  cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r <= '0;
      cal_p14_r  <= '0;
      cal_p58_r  <= '0;
      cal_p9_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_TEMP: cal_temp_r <= cfg_pwdata[47:0];
        REG_P1_4: cal_p14_r  <= cfg_pwdata;
        REG_P5_8: cal_p58_r  <= cfg_pwdata;
        REG_P9:   cal_p9_r   <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {48'd0, cal_temp_r[15:0]};
  assign t2 = sx16(cal_temp_r[31:16]);
  assign t3 = sx16(cal_temp_r[47:32]);
  assign p1 = {48'd0, cal_p14_r[15:0]};
  assign p2 = sx16(cal_p14_r[31:16]);
  assign p3 = sx16(cal_p14_r[47:32]);
  assign p4 = sx16(cal_p14_r[63:48]);
  assign p5 = sx16(cal_p58_r[15:0]);
  assign p6 = sx16(cal_p58_r[31:16]);
  assign p7 = sx16(cal_p58_r[47:32]);
  assign p8 = sx16(cal_p58_r[63:48]);
  assign p9 = sx16(cal_p9_r);

  // sequencer
  logic [4:0]         state_r;
  logic               issued_r;
  logic [19:0]        up_r, ut_r;
  logic signed [63:0] v1_r, sq_r, tfine_r, hh_r, w_r, v_r, e_r, n_r;
  logic signed [63:0] p_r, u_r, a_r, sum_r, pc_r;
  logic [23:0]        pres_r, filt_r;
  logic               fault_r, upd_r;
  logic               out_valid_r;
  logic signed [15:0] out_temp_r;
  logic [23:0]        out_pres_r, out_filt_r;
  logic               out_upd_r, out_fault_r;

  psc_pkg::md_req_t   md_req;
  psc_pkg::md_rsp_t   md_rsp;
  logic signed [63:0] res;
  logic               is_op;
  logic signed [63:0] h, x1, d, e_c, n_c, acc, t9;
  logic [28:0]        f19;
  logic signed [15:0] temp_c;

  assign res = md_rsp.result;
  assign h   = tfine_r - 64'sd128000;
  assign x1  = {47'd0, ut_r[19:3]} - {47'd0, cal_temp_r[15:0], 1'b0};
  assign d   = {48'd0, ut_r[19:4]} - t1;
  assign e_c = (64'sd1 <<< 55) + v_r;
  assign n_c = ({43'd0, (21'h100000 - {1'b0, up_r})} <<< 31) - w_r;
  assign f19 = {1'b0, filt_r, 4'd0} + {4'd0, filt_r, 1'b0} + {5'd0, filt_r};
  assign acc = sat_add(pc_r, {35'd0, f19} <<< FRAC_BITS);
  assign t9  = tfine_r >>> 9;

  always_comb begin
    if (t9 > 64'sd32767) begin
      temp_c = 16'sh7FFF;
    end else if (t9 < -64'sd32768) begin
      temp_c = 16'sh8000;
    end else begin
      temp_c = t9[15:0];
    end
  end

  always_comb begin
    is_op           = 1'b1;
    md_req.mul_only = 1'b1;
    md_req.a        = 64'd0;
    md_req.b        = 64'd0;
    md_req.c        = 64'd1;
    case (state_r)
      S_M1: begin md_req.a = x1;   md_req.b = t2; end
      S_M2: begin md_req.a = d;    md_req.b = d;  end
      S_M3: begin md_req.a = sq_r; md_req.b = t3; end
      S_HH: begin md_req.a = h;    md_req.b = h;  end
      S_W1: begin md_req.a = hh_r; md_req.b = p6; end
      S_W2: begin md_req.a = h;    md_req.b = p5; end
      S_V1: begin md_req.a = hh_r; md_req.b = p3; end
      S_V2: begin md_req.a = h;    md_req.b = p2; end
      S_D1: begin
        md_req.mul_only = 1'b0;
        md_req.a = n_r; md_req.b = 64'sd6250; md_req.c = p1;
      end
      S_D2: begin
        md_req.mul_only = 1'b0;
        md_req.a = p_r; md_req.b = SCALE_Q; md_req.c = e_r;
      end
      S_D3: begin
        md_req.mul_only = 1'b0;
        md_req.a = p_r; md_req.b = p9; md_req.c = 64'sd1 <<< 31;
      end
      S_D4: begin
        md_req.mul_only = 1'b0;
        md_req.a = u_r; md_req.b = p_r; md_req.c = ONE_Q;
      end
      S_D5: begin
        md_req.mul_only = 1'b0;
        md_req.a = p_r; md_req.b = p8; md_req.c = 64'sd32768;
      end
      S_D6: begin
        md_req.mul_only = 1'b0;
        md_req.a = sum_r; md_req.b = 64'sd1; md_req.c = 64'sd16;
      end
      S_D7: begin
        md_req.mul_only = 1'b0;
        md_req.a = p_r; md_req.b = 64'sd100; md_req.c = 64'sd1;
      end
      S_D8: begin
        md_req.mul_only = 1'b0;
        md_req.a = pc_r; md_req.b = 64'sd1; md_req.c = ONE_Q;
      end
      S_D9: begin
        md_req.mul_only = 1'b0;
        md_req.a = acc; md_req.b = 64'sd1; md_req.c = DIV20_Q;
      end
      default: is_op = 1'b0;
    endcase
    md_req.start = is_op && !issued_r;
  end

  psc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign in_chan.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (md_req.start) begin
        issued_r <= 1'b1;
      end
      if (out_chan.valid && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (is_op && md_rsp.done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            up_r    <= in_chan.raw_pressure;
            ut_r    <= in_chan.raw_temperature;
            fault_r <= 1'b0;
            upd_r   <= 1'b0;
            pres_r  <= '0;
            state_r <= S_M1;
          end
        end
        S_EN: begin
          e_r     <= e_c;
          n_r     <= n_c;
          fault_r <= (p1 == 64'sd0) || (e_c == 64'sd0);
          state_r <= ((p1 == 64'sd0) || (e_c == 64'sd0)) ? S_DONE : S_D1;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= temp_c;
            out_pres_r  <= pres_r;
            out_filt_r  <= filt_r;
            out_upd_r   <= upd_r;
            out_fault_r <= fault_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          if (is_op && md_rsp.done) begin
            case (state_r)
              S_M1: begin v1_r <= res >>> 11; state_r <= S_M2; end
              S_M2: begin sq_r <= res >>> 12; state_r <= S_M3; end
              S_M3: begin tfine_r <= v1_r + (res >>> 14); state_r <= S_HH; end
              S_HH: begin hh_r <= res; state_r <= S_W1; end
              S_W1: begin w_r <= res; state_r <= S_W2; end
              S_W2: begin
                w_r     <= w_r + (res <<< 17) + (p4 <<< 35);
                state_r <= S_V1;
              end
              S_V1: begin v_r <= res; state_r <= S_V2; end
              S_V2: begin v_r <= v_r + (res <<< 20); state_r <= S_EN; end
              S_D1: begin p_r <= res; state_r <= S_D2; end
              S_D2: begin p_r <= res; state_r <= S_D3; end
              S_D3: begin u_r <= res; state_r <= S_D4; end
              S_D4: begin a_r <= res; state_r <= S_D5; end
              S_D5: begin
                sum_r   <= sat_add(sat_add(a_r, res), p7 <<< FRAC_BITS);
                state_r <= S_D6;
              end
              S_D6: begin p_r <= sat_add(p_r, res); state_r <= S_D7; end
              S_D7: begin pc_r <= res; state_r <= S_D8; end
              S_D8: begin
                pres_r  <= clamp24(res);
                state_r <= (pc_r > THRESH_Q) ? S_D9 : S_DONE;
              end
              S_D9: begin
                filt_r  <= clamp24(res);
                upd_r   <= 1'b1;
                state_r <= S_DONE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.temperature_tenths   = out_temp_r;
  assign out_chan.pressure_centipascal = out_pres_r;
  assign out_chan.pressure_filtered    = out_filt_r;
  assign out_chan.filter_updated       = out_upd_r;
  assign out_chan.divide_fault         = out_fault_r;

  `PSC_ASSERT_IMP(a_fault_no_update, clk, rst_n, out_chan.valid,
                  !(out_chan.filter_updated && out_chan.divide_fault))
  `PSC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready,
                  !in_chan.ready)
  `PSC_ASSERT_IMP(a_unit_idle_on_start, clk, rst_n, md_req.start, !md_rsp.busy)
endmodule
`default_nettype wire

// ----- tb/tb_pressure_sensor_compensation.sv -----
// self-checking testbench for pressure_sensor_compensation
// depends on psc_ifs (channel interfaces) and the rtl top level; a scoreboard
// class predicts each result word from the calibration registers and filter state
`timescale 1ns / 1ps
module tb_pressure_sensor_compensation;
  localparam int FRAC = 16;
  localparam logic [4:0] ADDR_CAL_TEMP = 5'd0;
  localparam logic [4:0] ADDR_CAL_P1_4 = 5'd8;
  localparam logic [4:0] ADDR_CAL_P5_8 = 5'd16;
  localparam logic [4:0] ADDR_CAL_P9 = 5'd24;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLDOFF_CYCLES = 4000;
  localparam int PHASES = 6;

  typedef struct {
    logic signed [15:0] temp_tenths;
    logic [23:0]        press_cpa;
    logic [23:0]        press_filt;
    logic               filt_upd;
    logic               div_fault;
  } comp_word_t;

  class comp_scoreboard;
    comp_word_t pending[$];
    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [15:0] press_cal_9;
    logic [23:0] filt;
    int mismatches;
    int checked;
    int faults;
    int updates;

    function void clear();
      temp_cal = '0;
      press_cal_lo = '0;
      press_cal_hi = '0;
      press_cal_9 = '0;
      filt = '0;
      mismatches = 0;
      checked = 0;
      faults = 0;
      updates = 0;
    endfunction

    function void set_reg(logic [4:0] addr, logic [63:0] val);
      case (addr)
        ADDR_CAL_TEMP: temp_cal = val[47:0];
        ADDR_CAL_P1_4: press_cal_lo = val;
        ADDR_CAL_P5_8: press_cal_hi = val;
        ADDR_CAL_P9: press_cal_9 = val[15:0];
        default: ;
      endcase
    endfunction

    static function longint sx(logic [15:0] v);
      return longint'(signed'(v));
    endfunction

    static function longint sum_sat(longint a, longint b);
      if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b)
        return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b)
        return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
      return a + b;
    endfunction

    // trunc(a*b/c) through a 128-bit product, saturated to signed 64 bits; zero when c is zero
    static function longint scale_div(longint a, longint b, longint c);
      logic neg;
      logic [63:0] ua, ub, uc;
      logic [127:0] q;
      neg = ((a < 0) != (b < 0)) != (c < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      uc = c < 0 ? -c : c;
      if (uc == 0) return 0;
      q = ({64'b0, ua} * {64'b0, ub}) / {64'b0, uc};
      if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function comp_word_t compensate(logic [19:0] up_raw, logic [19:0] ut_raw);
      comp_word_t r;
      longint one, up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint v1, d, v2, tfine, tmp, h, w, v, e, n;
      longint tq, p, u, a, b, s, pc, whole, acc, f;
      one = longint'(1) << FRAC;
      up = longint'({44'b0, up_raw});
      ut = longint'({44'b0, ut_raw});
      t1 = longint'({48'b0, temp_cal[15:0]});
      t2 = sx(temp_cal[31:16]);
      t3 = sx(temp_cal[47:32]);
      p1 = longint'({48'b0, press_cal_lo[15:0]});
      p2 = sx(press_cal_lo[31:16]);
      p3 = sx(press_cal_lo[47:32]);
      p4 = sx(press_cal_lo[63:48]);
      p5 = sx(press_cal_hi[15:0]);
      p6 = sx(press_cal_hi[31:16]);
      p7 = sx(press_cal_hi[47:32]);
      p8 = sx(press_cal_hi[63:48]);
      p9 = sx(press_cal_9);
      v1 = (((ut >>> 3) - 2 * t1) * t2) >>> 11;
      d = (ut >>> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      tfine = v1 + v2;
      tmp = tfine >>> 9;
      if (tmp > 32767) tmp = 32767;
      if (tmp < -32768) tmp = -32768;
      r.temp_tenths = tmp[15:0];
      h = tfine - 128000;
      w = h * h * p6 + h * p5 * (longint'(1) << 17) + p4 * (longint'(1) << 35);
      v = h * h * p3 + h * p2 * (longint'(1) << 20);
      e = (longint'(1) << 55) + v;
      n = (1048576 - up) * (longint'(1) << 31) - w;
      r.div_fault = (p1 == 0) || (e == 0);
      r.filt_upd = 1'b0;
      r.press_cpa = '0;
      if (!r.div_fault) begin
        tq = scale_div(n, 6250, p1);
        p = scale_div(tq, longint'(1) << (24 + FRAC), e);
        u = scale_div(p, p9, longint'(1) << 31);
        a = scale_div(u, p, one);
        b = scale_div(p, p8, 32768);
        s = sum_sat(sum_sat(a, b), p7 * one);
        p = sum_sat(p, scale_div(s, 1, 16));
        pc = scale_div(p, 100, 1);
        whole = scale_div(pc, 1, one);
        if (whole < 0) r.press_cpa = '0;
        else if (whole > 64'sh00FF_FFFF) r.press_cpa = 24'hFF_FFFF;
        else r.press_cpa = whole[23:0];
        if (pc > 5000000 * one) begin
          acc = sum_sat(pc, longint'({40'b0, filt}) * 19 * one);
          f = scale_div(acc, 1, 20 * one);
          if (f > 64'sh00FF_FFFF) f = 64'sh00FF_FFFF;
          if (f < 0) f = 0;
          filt = f[23:0];
          r.filt_upd = 1'b1;
        end
      end
      r.press_filt = filt;
      return r;
    endfunction

    function void note_sample(logic [19:0] up_raw, logic [19:0] ut_raw);
      pending.push_back(compensate(up_raw, ut_raw));
    endfunction

    function void check_word(comp_word_t got);
      comp_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: temp %0d press %0d",
                                       got.temp_tenths, got.press_cpa);
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (exp_w.div_fault) faults++;
      if (exp_w.filt_upd) updates++;
      if (got.temp_tenths !== exp_w.temp_tenths || got.press_cpa !== exp_w.press_cpa ||
          got.press_filt !== exp_w.press_filt || got.filt_upd !== exp_w.filt_upd ||
          got.div_fault !== exp_w.div_fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch word %0d: exp t=%0d p=%0d f=%0d u=%0b z=%0b ",
                    "got t=%0d p=%0d f=%0d u=%0b z=%0b"},
                   checked, exp_w.temp_tenths, exp_w.press_cpa, exp_w.press_filt,
                   exp_w.filt_upd, exp_w.div_fault, got.temp_tenths, got.press_cpa,
                   got.press_filt, got.filt_upd, got.div_fault);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  psc_in_if in_if ();
  psc_out_if out_if ();

  pressure_sensor_compensation #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  comp_scoreboard sb;
  int snd_idle_pct;
  int rcv_idle_pct;
  int samples_in;
  int quiet_cycles;
  bit holdoff_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!holdoff_done && samples_in == 40) begin
        holdoff_done = 1'b1;
        hold = HOLDOFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    comp_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.temp_tenths = out_if.temperature_tenths;
      got.press_cpa = out_if.pressure_centipascal;
      got.press_filt = out_if.pressure_filtered;
      got.filt_upd = out_if.filter_updated;
      got.div_fault = out_if.divide_fault;
      sb.check_word(got);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [4:0] addr, logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(addr, val);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_sample(logic [19:0] up_raw, logic [19:0] ut_raw);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.raw_pressure <= up_raw;
    in_if.raw_temperature <= ut_raw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(up_raw, ut_raw);
    samples_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic load_calibration(int idx);
    logic [63:0] c0, c1, c2, c3;
    case (idx)
      0, 5: begin
        // typical sensor trim
        c0 = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
        c1 = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        c2 = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        c3 = 64'd6000;
        if (idx == 5) begin
          c1[31:16] = c1[31:16] + 16'($urandom_range(400));
          c2[47:32] = 16'($urandom_range(30000));
        end
      end
      1: begin
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
      end
      2: begin
        c0 = '1;
        c1 = '1;
        c2 = '1;
        c3 = '1;
      end
      3: begin
        c0 = {16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF};
        c1 = {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
        c2 = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        c3 = 64'h8000;
      end
      default: begin
        c0 = {$urandom, $urandom};
        c1 = {$urandom, $urandom};
        c2 = {$urandom, $urandom};
        c3 = {$urandom, $urandom};
      end
    endcase
    reg_write(ADDR_CAL_TEMP, c0);
    reg_write(ADDR_CAL_P1_4, c1);
    reg_write(ADDR_CAL_P5_8, c2);
    reg_write(ADDR_CAL_P9, c3);
  endtask

  task automatic random_sample();
    logic [19:0] up_raw, ut_raw;
    case ($urandom_range(9))
      0: begin
        up_raw = 20'($urandom);
        ut_raw = 20'($urandom);
      end
      1: begin
        up_raw = $urandom_range(1) ? 20'hFFFFF : 20'h0;
        ut_raw = $urandom_range(1) ? 20'hFFFFF : 20'h0;
      end
      default: begin
        up_raw = 20'($urandom_range(600000, 250000));
        ut_raw = 20'($urandom_range(600000, 400000));
      end
    endcase
    send_sample(up_raw, ut_raw);
  endtask

  initial begin
    sb = new();
    sb.clear();
    samples_in = 0;
    holdoff_done = 1'b0;
    snd_idle_pct = 20;
    rcv_idle_pct = 76;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.raw_pressure = '0;
    in_if.raw_temperature = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset calibration: all zero, so every word takes the divide fault path
    send_sample(20'd415148, 20'd519888);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) begin
        snd_idle_pct = 76;
        rcv_idle_pct = 20;
      end else if (ph == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      load_calibration(ph);
      if (ph == 0) begin
        send_sample(20'd415148, 20'd519888);
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h00000, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'h00000);
        send_sample(20'h00001, 20'd519888);
        send_sample(20'd900000, 20'd519888);
        send_sample(20'd200000, 20'd519888);
        send_sample(20'd415148, 20'd300000);
        send_sample(20'd415148, 20'd700000);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
      end
      repeat (115) random_sample();
      drain();
    end

    repeat (50) @(posedge clk);
    $display("checked %0d result words over %0d calibration sets", sb.checked, PHASES + 1);
    $display("%0d divide faults, %0d filter updates", sb.faults, sb.updates);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_ifs.sv
rtl/psc_muldiv.sv
rtl/pressure_sensor_compensation.sv
tb/tb_pressure_sensor_compensation.sv
